/* rtl/core/shs_pkg.sv */
// Shared types and constants of the SHA-256 stream hasher.
`default_nettype none

package shs_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int BLOCK_BYTES     = 64;
    localparam int LEN_START       = 56;
    localparam int ROUNDS          = 64;
    localparam int DIGEST_WORDS    = 8;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    localparam logic [31:0] HASH_IV [DIGEST_WORDS] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       message_end;
    } shs_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_FOLD,
        ST_OUT
    } shs_state_t;

endpackage

`default_nettype wire

/* rtl/core/sha256_stream_hasher_top.sv */
// Top level of the SHA-256 stream hasher: input queue and hashing back end.
// Message bytes are shifted into a 64-byte block; each full block is then hashed in
// the one-round-per-cycle compression loop, during which no new bytes are taken.
// At message end padding adds one or two compressions, then eight digest beats
// follow, one per cycle while m_ready is high.
// Synchronous active-low reset empties the queue and restores the initial hash.
`default_nettype none

module sha256_stream_hasher_top
    import shs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_byte_present,
    input  wire logic        s_message_end,
    input  wire logic        s_valid,
    output logic             s_ready,
    output logic [31:0]      m_digest_word,
    output logic [2:0]       m_word_number,
    output logic             m_final_word,
    output logic             m_valid,
    input  wire logic        m_ready
);

    logic      q_valid;
    logic      q_ready;
    shs_item_t q_item;

    shs_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_data_byte   (s_data_byte),
        .s_byte_present(s_byte_present),
        .s_message_end (s_message_end),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item)
    );

    shs_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item),
        .m_digest_word(m_digest_word),
        .m_word_number(m_word_number),
        .m_final_word (m_final_word),
        .m_valid      (m_valid),
        .m_ready      (m_ready)
    );

`ifndef SYNTHESIS
    a_final_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_final_word |-> m_word_number == 3'd7)
        else $error("final digest beat not on word seven");

    a_digest_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_final_word |=> !m_valid)
        else $error("digest beats continue after the final word");

    a_word_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_final_word |=>
            m_valid && (m_word_number == 3'($past(m_word_number) + 3'd1)))
        else $error("digest words out of order");
`endif

endmodule

`default_nettype wire

/* rtl/core/shs_front.sv */
// Input front: drops empty beats and queues message beats for the back end.
`default_nettype none

module shs_front
    import shs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_byte_present,
    input  wire logic       s_message_end,
    input  wire logic       s_valid,
    output logic            s_ready,
    output logic            q_valid,
    input  wire logic       q_ready,
    output shs_item_t       q_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    shs_item_t            queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 push;
    logic                 pop;
    logic                 useful;

    assign useful  = s_byte_present | s_message_end;
    assign s_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push    = s_valid & s_ready & useful;
    assign q_valid = (count_reg != '0);
    assign pop     = q_valid & q_ready;
    assign q_item  = queue_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= '{data_byte: s_data_byte,
                                       byte_present: s_byte_present,
                                       message_end: s_message_end};
        end
    end

endmodule

`default_nettype wire

/* rtl/core/shs_back.sv */
// Back end: block loading, padding, 64-round compression and digest output.
`default_nettype none

module shs_back
    import shs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_valid,
    output logic             q_ready,
    input  wire shs_item_t   q_item,
    output logic [31:0]      m_digest_word,
    output logic [2:0]       m_word_number,
    output logic             m_final_word,
    output logic             m_valid,
    input  wire logic        m_ready
);

    localparam logic [5:0] LAST_FILL  = 6'(BLOCK_BYTES - 1);
    localparam logic [5:0] LEN_FILL   = 6'(LEN_START);
    localparam logic [5:0] LAST_ROUND = 6'(ROUNDS - 1);
    localparam logic [2:0] LAST_WORD  = 3'(DIGEST_WORDS - 1);

    shs_state_t    state_reg, state_next;
    logic [5:0]    fill_reg, fill_next;
    logic [60:0]   cnt_reg, cnt_next;
    logic [511:0]  blk_reg, blk_next;
    logic [31:0]   v_reg [DIGEST_WORDS];
    logic [31:0]   v_next [DIGEST_WORDS];
    logic [31:0]   h_reg [DIGEST_WORDS];
    logic [31:0]   h_next [DIGEST_WORDS];
    logic [5:0]    rnd_reg, rnd_next;
    logic [63:0]   len_reg, len_next;
    logic          pad_first_reg, pad_first_next;
    logic          len_ok_reg, len_ok_next;
    logic          end_pend_reg, end_pend_next;
    logic [2:0]    out_idx_reg, out_idx_next;

    logic [7:0]    pad_byte;
    logic          len_phase;
    logic [31:0]   w_new;
    logic [31:0]   t1;
    logic [31:0]   t2;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

    assign len_phase = len_ok_reg && (fill_reg >= LEN_FILL);
    assign pad_byte  = pad_first_reg ? PAD_BYTE : (len_phase ? len_reg[63:56] : 8'h00);

    // Schedule taps: word 0 is W[t-16], 1 is W[t-15], 9 is W[t-7], 14 is W[t-2].
    always_comb begin
        if (rnd_reg < 6'd16) begin
            w_new = blk_reg[511:480];
        end else begin
            w_new = blk_reg[511:480] + sig0(blk_reg[479:448]) + blk_reg[223:192]
                  + sig1(blk_reg[63:32]);
        end
        t1 = v_reg[7] + bsig1(v_reg[4]) + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + ROUND_K[rnd_reg] + w_new;
        t2 = bsig0(v_reg[0])
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    if (q_item.byte_present && fill_reg == LAST_FILL) begin
                        state_next = ST_COMP;
                    end else if (q_item.message_end) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (fill_reg == LAST_FILL) begin
                    state_next = ST_COMP;
                end
            end
            ST_COMP: begin
                if (rnd_reg == LAST_ROUND) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (len_ok_reg) begin
                    state_next = ST_OUT;
                end else if (end_pend_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (m_ready && out_idx_reg == LAST_WORD) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        fill_next      = fill_reg;
        cnt_next       = cnt_reg;
        blk_next       = blk_reg;
        rnd_next       = rnd_reg;
        len_next       = len_reg;
        pad_first_next = pad_first_reg;
        len_ok_next    = len_ok_reg;
        end_pend_next  = end_pend_reg;
        out_idx_next   = out_idx_reg;
        v_next         = v_reg;
        h_next         = h_reg;
        q_ready        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    if (q_item.byte_present) begin
                        blk_next  = {blk_reg[503:0], q_item.data_byte};
                        fill_next = fill_reg + 6'd1;
                        cnt_next  = cnt_reg + 61'd1;
                        if (fill_reg == LAST_FILL) begin
                            v_next        = h_reg;
                            rnd_next      = '0;
                            len_ok_next   = 1'b0;
                            end_pend_next = q_item.message_end;
                        end
                    end
                    pad_first_next = q_item.message_end;
                end
            end
            ST_PAD: begin
                blk_next  = {blk_reg[503:0], pad_byte};
                fill_next = fill_reg + 6'd1;
                if (pad_first_reg) begin
                    len_next       = {cnt_reg, 3'b000};
                    len_ok_next    = (fill_reg < LEN_FILL);
                    pad_first_next = 1'b0;
                end else if (len_phase) begin
                    len_next = {len_reg[55:0], 8'h00};
                end
                if (fill_reg == LAST_FILL) begin
                    v_next        = h_reg;
                    rnd_next      = '0;
                    end_pend_next = 1'b1;
                    if (pad_first_reg) begin
                        len_ok_next = 1'b0;
                    end
                end
            end
            ST_COMP: begin
                blk_next = {blk_reg[479:0], w_new};
                rnd_next = rnd_reg + 6'd1;
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
            end
            ST_FOLD: begin
                for (int i = 0; i < DIGEST_WORDS; i++) begin
                    h_next[i] = h_reg[i] + v_reg[i];
                end
                out_idx_next = '0;
                if (!len_ok_reg && end_pend_reg) begin
                    len_ok_next = 1'b1;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == LAST_WORD) begin
                        h_next        = HASH_IV;
                        cnt_next      = '0;
                        fill_next     = '0;
                        len_ok_next   = 1'b0;
                        end_pend_next = 1'b0;
                    end
                end
            end
            default: begin
                q_ready = 1'b0;
            end
        endcase
    end

    assign m_valid       = (state_reg == ST_OUT);
    assign m_digest_word = h_reg[out_idx_reg];
    assign m_word_number = out_idx_reg;
    assign m_final_word  = (out_idx_reg == LAST_WORD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            rnd_reg       <= '0;
            pad_first_reg <= 1'b0;
            len_ok_reg    <= 1'b0;
            end_pend_reg  <= 1'b0;
            out_idx_reg   <= '0;
            h_reg         <= HASH_IV;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            cnt_reg       <= cnt_next;
            rnd_reg       <= rnd_next;
            pad_first_reg <= pad_first_next;
            len_ok_reg    <= len_ok_next;
            end_pend_reg  <= end_pend_next;
            out_idx_reg   <= out_idx_next;
            h_reg         <= h_next;
        end
    end

    always_ff @(posedge aclk) begin
        blk_reg <= blk_next;
        len_reg <= len_next;
        v_reg   <= v_next;
    end

endmodule

`default_nettype wire

/* dv/tb_sha256_stream_hasher_top.sv */
// Self-checking testbench for sha256_stream_hasher_top: byte streams in, digest words checked.
`timescale 1ns / 1ps

module tb_sha256_stream_hasher_top;
    import shs_pkg::*;

    localparam int TOTAL_ITEMS    = 255;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 300;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    class digest_scoreboard;
        logic [31:0]  hash_words [8];
        logic [7:0]   block_bytes [64];
        int           fill;
        logic [63:0]  msg_bits;
        digest_beat_t expected_digest_q [$];
        int           errors;
        int           messages;
        int           bytes_taken;
        int           beats_checked;

        function new();
            foreach (hash_words[i]) hash_words[i] = HASH_IV[i];
            foreach (block_bytes[i]) block_bytes[i] = 8'h00;
            fill          = 0;
            msg_bits      = 64'd0;
            errors        = 0;
            messages      = 0;
            bytes_taken   = 0;
            beats_checked = 0;
        endfunction

        function automatic logic [31:0] rotr(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            logic [31:0] w [64];
            logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
            for (int t = 0; t < 16; t++) begin
                w[t] = {block_bytes[4*t], block_bytes[4*t+1],
                        block_bytes[4*t+2], block_bytes[4*t+3]};
            end
            for (int t = 16; t < ROUNDS; t++) begin
                s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
                s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
                w[t] = w[t-16] + s0 + w[t-7] + s1;
            end
            a = hash_words[0]; b = hash_words[1]; c = hash_words[2]; d = hash_words[3];
            e = hash_words[4]; f = hash_words[5]; g = hash_words[6]; h = hash_words[7];
            for (int t = 0; t < ROUNDS; t++) begin
                t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                     + ROUND_K[t] + w[t];
                t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
                h = g; g = f; f = e; e = d + t1;
                d = c; c = b; b = a; a = t1 + t2;
            end
            hash_words[0] += a; hash_words[1] += b; hash_words[2] += c; hash_words[3] += d;
            hash_words[4] += e; hash_words[5] += f; hash_words[6] += g; hash_words[7] += h;
        endfunction

        function void absorb_item(logic [7:0] data, logic present, logic finish_msg);
            logic [63:0]  total;
            digest_beat_t beat;
            if (present) begin
                bytes_taken++;
                block_bytes[fill] = data;
                fill++;
                if (fill == BLOCK_BYTES) begin
                    compress();
                    msg_bits += 64'd512;
                    fill = 0;
                end
            end
            if (!finish_msg) return;
            total = msg_bits + 64'(fill) * 64'd8;
            block_bytes[fill] = PAD_BYTE;
            fill++;
            if (fill > LEN_START) begin
                for (int i = fill; i < BLOCK_BYTES; i++) block_bytes[i] = 8'h00;
                compress();
                fill = 0;
            end
            for (int i = fill; i < LEN_START; i++) block_bytes[i] = 8'h00;
            for (int i = 0; i < 8; i++) block_bytes[63-i] = total[i*8 +: 8];
            compress();
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                beat.word  = hash_words[i];
                beat.index = 3'(i);
                beat.last  = (i == DIGEST_WORDS - 1);
                expected_digest_q.push_back(beat);
            end
            foreach (hash_words[i]) hash_words[i] = HASH_IV[i];
            fill     = 0;
            msg_bits = 64'd0;
            messages++;
        endfunction

        function void check_digest_beat(logic [31:0] word, logic [2:0] index, logic last);
            digest_beat_t exp_beat;
            if (expected_digest_q.size() == 0) begin
                $display("%0t: unexpected digest beat word=%h index=%0d last=%0b",
                         $time, word, index, last);
                errors++;
                return;
            end
            exp_beat = expected_digest_q.pop_front();
            beats_checked++;
            if (word !== exp_beat.word) begin
                $display("%0t: digest_word mismatch expected %h actual %h",
                         $time, exp_beat.word, word);
                errors++;
            end
            if (index !== exp_beat.index) begin
                $display("%0t: word_number mismatch expected %0d actual %0d",
                         $time, exp_beat.index, index);
                errors++;
            end
            if (last !== exp_beat.last) begin
                $display("%0t: final_word mismatch expected %0b actual %0b",
                         $time, exp_beat.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_digest_q.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic [7:0]  s_data_byte;
    logic        s_byte_present;
    logic        s_message_end;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] m_digest_word;
    logic [2:0]  m_word_number;
    logic        m_final_word;
    logic        m_valid;
    logic        m_ready;

    digest_scoreboard digests = new();
    bit calm = 1'b0;
    int items_sent = 0;
    int idle_cycles = 0;
    int stall_left = 0;

    sha256_stream_hasher_top u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_data_byte    (s_data_byte),
        .s_byte_present (s_byte_present),
        .s_message_end  (s_message_end),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .m_digest_word  (m_digest_word),
        .m_word_number  (m_word_number),
        .m_final_word   (m_final_word),
        .m_valid        (m_valid),
        .m_ready        (m_ready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(input logic [7:0] data, input logic present, input logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data_byte    <= data;
        s_byte_present <= present;
        s_message_end  <= fin;
        s_valid        <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        digests.absorb_item(data, present, fin);
        items_sent++;
    endtask

    task automatic send_message(input int len, input bit end_on_byte);
        logic last;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 8) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            last = end_on_byte && (i == len - 1);
            send_item(8'($urandom_range(0, 255)), 1'b1, last);
        end
        if (!end_on_byte || len == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // result side: check accepted beats, stall at random
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                digests.check_digest_beat(m_digest_word, m_word_number, m_final_word);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 30) stall_left = pick_gap();
            end
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready && digests.pending() != 0))
                idle_cycles = 0;
            else idle_cycles++;
        end
        $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int r;
        int len;
        s_data_byte    <= 8'h00;
        s_byte_present <= 1'b0;
        s_message_end  <= 1'b0;
        s_valid        <= 1'b0;
        aresetn        <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        calm = 1'b1;
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        calm = 1'b0;
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'h5A, 1'b0, 1'b1);
        send_item(8'h80, 1'b1, 1'b1);
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);

        // hit padding boundaries first: last fit, extra block, full block
        send_message(55, 1'b1);
        send_message(56, 1'b0);
        send_message(64, 1'b1);
        while (items_sent < TOTAL_ITEMS) begin
            calm = ($urandom_range(0, 99) < 15);
            r = $urandom_range(0, 99);
            if (r < 55)      len = $urandom_range(0, 8);
            else if (r < 70) len = $urandom_range(9, 49);
            else if (r < 95) len = $urandom_range(50, 66);
            else             len = $urandom_range(110, 130);
            send_message(len, 1'($urandom_range(0, 1)));
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        while (digests.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Hashed %0d messages from %0d bytes over %0d input items.",
                 digests.messages, digests.bytes_taken, items_sent);
        $display("Checked %0d digest words, %0d mismatches.",
                 digests.beats_checked, digests.errors);
        if (digests.errors == 0 && digests.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/shs_pkg.sv
rtl/core/shs_front.sv
rtl/core/shs_back.sv
rtl/core/sha256_stream_hasher_top.sv
dv/tb_sha256_stream_hasher_top.sv
